>>> design/tdc_pkg.sv
// ============================================================================
// tdc_pkg
// Shared types, widths and constants of the tilt to drive command block.
// ============================================================================
`default_nettype none

package tdc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WEIGHT = 2'd0;
  localparam logic [1:0] CFG_PITCH_DZ = 2'd1;
  localparam logic [1:0] CFG_ROLL_DZ = 2'd2;

  localparam int CFG_W = 9;
  localparam int DZ_W = 7;
  localparam int SMP_W = 16;
  localparam int FLT_W = 24;

  // Sum of squares and its integer square root.
  localparam int SQ_W = 48;
  localparam int RT_W = 24;

  // CORDIC datapath: x and y scaled by 2^16, angle in Q20 degrees.
  localparam int CX_W = 44;
  localparam int Z_W = 30;
  localparam int ATAN_STEPS = 24;
  localparam logic signed [Z_W-1:0] DEG180_Q20 = 30'sd188743680;

  // Deadzone mapping.
  localparam int QN_W = 15;
  localparam int DEN_W = 7;
  localparam logic [DZ_W-1:0] DZ_MAX = 7'd89;
  localparam logic [DEN_W-1:0] DEG90 = 7'd90;
  localparam logic [6:0] DRIVE_MAX = 7'd100;
  localparam logic [CFG_W-1:0] WEIGHT_FULL = 9'd256;

  typedef struct packed {
    logic                   vld;
    logic                   roll;
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_bus_t;

  // atan(2^-i) in degrees, Q20.
  function automatic logic signed [Z_W-1:0] atan_q20(input int idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0: v = 30'sd47185920;
      1: v = 30'sd27855475;
      2: v = 30'sd14718068;
      3: v = 30'sd7471121;
      4: v = 30'sd3750058;
      5: v = 30'sd1876857;
      6: v = 30'sd938658;
      7: v = 30'sd469357;
      8: v = 30'sd234682;
      9: v = 30'sd117342;
      10: v = 30'sd58671;
      11: v = 30'sd29335;
      12: v = 30'sd14668;
      13: v = 30'sd7334;
      14: v = 30'sd3667;
      15: v = 30'sd1833;
      16: v = 30'sd917;
      17: v = 30'sd458;
      18: v = 30'sd229;
      19: v = 30'sd115;
      20: v = 30'sd57;
      21: v = 30'sd29;
      22: v = 30'sd14;
      23: v = 30'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> design/tdc_cordic_cell.sv
// ============================================================================
// tdc_cordic_cell
// One vectoring CORDIC iteration with a fixed shift, registered toward the
// next cell of the chain.
// ============================================================================
`default_nettype none

module tdc_cordic_cell
  import tdc_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cordic_bus_t bus_in,
  output cordic_bus_t      bus_out
);

  localparam logic signed [Z_W-1:0] ATAN = atan_q20(STAGE);

  logic signed [CX_W-1:0] dx;
  logic signed [CX_W-1:0] dy;
  cordic_bus_t            bus_nxt;
  cordic_bus_t            bus_r;

  always_comb begin
    dx = $signed(bus_in.y) >>> STAGE;
    dy = $signed(bus_in.x) >>> STAGE;
    bus_nxt = bus_in;
    // A vector already on the axis is left alone.
    if ($signed(bus_in.y) > 0) begin
      bus_nxt.x = $signed(bus_in.x) + dx;
      bus_nxt.y = $signed(bus_in.y) - dy;
      bus_nxt.z = $signed(bus_in.z) + ATAN;
    end else if ($signed(bus_in.y) < 0) begin
      bus_nxt.x = $signed(bus_in.x) - dx;
      bus_nxt.y = $signed(bus_in.y) + dy;
      bus_nxt.z = $signed(bus_in.z) - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    bus_r.roll <= bus_nxt.roll;
    bus_r.x <= bus_nxt.x;
    bus_r.y <= bus_nxt.y;
    bus_r.z <= bus_nxt.z;
    if (!rst_n) begin
      bus_r.vld <= 1'b0;
    end else begin
      bus_r.vld <= bus_nxt.vld;
    end
  end

  assign bus_out = bus_r;

endmodule

`default_nettype wire

>>> design/tdc_isqrt.sv
// ============================================================================
// tdc_isqrt
// Integer square root, one result bit per cycle, floor rounding.
// ============================================================================
`default_nettype none

module tdc_isqrt
  import tdc_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [SQ_W-1:0] radicand,
  output logic                 done,
  output logic [RT_W-1:0]      root
);

  localparam int CNT_W = $clog2(RT_W);
  localparam int REM_W = RT_W + 1;

  logic [SQ_W-1:0]  rad_r;
  logic [REM_W-1:0] rem_r;
  logic [RT_W-1:0]  root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic [REM_W+1:0] rem_t;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             take;

  always_comb begin
    rem_t = {rem_r, rad_r[SQ_W-1 -: 2]};
    trial = (REM_W+2)'({root_r, 2'b01});
    take = (rem_t >= trial);
    diff = rem_t - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      run_r <= 1'b1;
      done_r <= 1'b0;
    end else if (run_r) begin
      run_r <= (cnt_r != CNT_W'(RT_W - 1));
      done_r <= (cnt_r == CNT_W'(RT_W - 1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r <= radicand;
      rem_r <= '0;
      root_r <= '0;
      cnt_r <= '0;
    end else if (run_r) begin
      rad_r <= {rad_r[SQ_W-3:0], 2'b00};
      rem_r <= take ? diff[REM_W-1:0] : rem_t[REM_W-1:0];
      root_r <= {root_r[RT_W-2:0], take};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

>>> design/tdc_div.sv
// ============================================================================
// tdc_div
// Restoring divider for the deadzone mapping, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module tdc_div
  import tdc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [QN_W-1:0]  num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [QN_W-1:0]       quot
);

  localparam int CNT_W = $clog2(QN_W);

  logic [QN_W-1:0]  num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [QN_W-1:0]  quot_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic [DEN_W:0]   rem_t;
  logic [DEN_W:0]   diff;
  logic             take;

  always_comb begin
    rem_t = {rem_r, num_r[QN_W-1]};
    take = (rem_t >= {1'b0, den_r});
    diff = rem_t - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      run_r <= 1'b1;
      done_r <= 1'b0;
    end else if (run_r) begin
      run_r <= (cnt_r != CNT_W'(QN_W - 1));
      done_r <= (cnt_r == CNT_W'(QN_W - 1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quot_r <= '0;
      cnt_r <= '0;
    end else if (run_r) begin
      num_r <= {num_r[QN_W-2:0], 1'b0};
      rem_r <= take ? diff[DEN_W-1:0] : rem_t[DEN_W-1:0];
      quot_r <= {quot_r[QN_W-2:0], take};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

>>> design/tilt_to_drive_command.sv
// ============================================================================
// tilt_to_drive_command
// Low-pass filters a three-axis accelerometer sample, derives pitch and roll
// with a chain of CORDIC cells and maps both angles to drive commands.
// ============================================================================
//
//   Channel  Handshake          Payload
//   -------  -----------------  -------------------------------------------
//   cfg      cfg_we             cfg_addr (register index), cfg_wdata
//   in       in_valid/in_ready  in_accel_x, in_accel_y, in_accel_z
//   out      out_valid/out_ready out_speed, out_steering, out_pitch_angle,
//                               out_roll_angle
//
// One transaction passes from acceptance until the result is loaded through
// the bit-serial square root, the cell chain for roll and the two deadzone
// dividers, plus the setup states. The next input is taken as soon as a
// result has moved into the output register. Reset is synchronous and active
// low; it restores the configuration defaults and clears the filter state.
// A stalled output only delays the loading of the next result.
//
`default_nettype none

module tilt_to_drive_command
  import tdc_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_addr,
  input  wire logic [CFG_W-1:0]         cfg_wdata,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [SMP_W-1:0]  in_accel_x,
  input  wire logic signed [SMP_W-1:0]  in_accel_y,
  input  wire logic signed [SMP_W-1:0]  in_accel_z,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [7:0]             out_speed,
  output logic signed [7:0]             out_steering,
  output logic signed [16:0]            out_pitch_angle,
  output logic signed [15:0]            out_roll_angle
);

  // Angle widths follow the fraction bits: the clamped angle spans plus or minus 180
  // degrees, and the rounding path keeps one extra bit before the clamp.
  localparam int ANG_W = ANGLE_FRAC_BITS + 10;
  localparam int SH = 20 - ANGLE_FRAC_BITS;
  localparam int RW = 31 - SH;
  localparam int PITCH_LIM = 180 * (2 ** ANGLE_FRAC_BITS);
  localparam int ROLL_LIM = 90 * (2 ** ANGLE_FRAC_BITS);
  localparam int PROD_W = ANG_W + 7;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL = 4'd1;
  localparam logic [3:0] S_SUM = 4'd2;
  localparam logic [3:0] S_ROOT = 4'd3;
  localparam logic [3:0] S_CORD = 4'd4;
  localparam logic [3:0] S_ANG = 4'd5;
  localparam logic [3:0] S_DIVGO = 4'd6;
  localparam logic [3:0] S_DIVW = 4'd7;
  localparam logic [3:0] S_OUT = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // Configuration registers.
  logic [CFG_W-1:0] weight_r;
  logic [DZ_W-1:0]  pdz_r;
  logic [DZ_W-1:0]  rdz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= 9'd128;
      pdz_r <= 7'd10;
      rdz_r <= 7'd10;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_WEIGHT: weight_r <= cfg_wdata;
        CFG_PITCH_DZ: pdz_r <= cfg_wdata[DZ_W-1:0];
        CFG_ROLL_DZ: rdz_r <= cfg_wdata[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  // The low-pass filter updates the three axes in the cycle the sample is
  // accepted. The weight saturates at one whole (256).
  logic [CFG_W-1:0] w_eff;
  logic [CFG_W-1:0] w_rest;

  assign w_eff = (weight_r > WEIGHT_FULL) ? WEIGHT_FULL : weight_r;
  assign w_rest = WEIGHT_FULL - w_eff;

  function automatic logic signed [FLT_W-1:0] lowpass(
    input logic [CFG_W-1:0]         w,
    input logic [CFG_W-1:0]         wr,
    input logic signed [SMP_W-1:0]  s,
    input logic signed [FLT_W-1:0]  f
  );
    logic signed [25:0] t1;
    logic signed [33:0] t2;
    logic signed [34:0] acc;
    t1 = $signed({1'b0, w}) * s;
    t2 = $signed({1'b0, wr}) * f;
    acc = $signed({t1[25], t1, 8'b0}) + 35'(t2);
    // Dropping the low byte of the sum is the floor division by 256.
    return acc[31:8];
  endfunction

  logic signed [FLT_W-1:0] fx_r;
  logic signed [FLT_W-1:0] fy_r;
  logic signed [FLT_W-1:0] fz_r;
  logic                    in_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_r <= '0;
      fy_r <= '0;
      fz_r <= '0;
    end else if (in_fire) begin
      fx_r <= lowpass(w_eff, w_rest, in_accel_x, fx_r);
      fy_r <= lowpass(w_eff, w_rest, in_accel_y, fy_r);
      fz_r <= lowpass(w_eff, w_rest, in_accel_z, fz_r);
    end
  end

  // Squares of x and z feed the square root for the roll denominator.
  logic signed [2*FLT_W-1:0] px;
  logic signed [2*FLT_W-1:0] pz;
  logic [SQ_W-2:0]           sqx_r;
  logic [SQ_W-2:0]           sqz_r;
  logic [SQ_W-1:0]           sq_sum;

  assign px = fx_r * fx_r;
  assign pz = fz_r * fz_r;
  assign sq_sum = {1'b0, sqx_r} + {1'b0, sqz_r};

  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      sqx_r <= px[SQ_W-2:0];
      sqz_r <= pz[SQ_W-2:0];
    end
  end

  logic            sqrt_done;
  logic [RT_W-1:0] sqrt_root;

  tdc_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_SUM),
    .radicand (sq_sum),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // Chain entry. Pitch enters right after filtering, roll once the root is
  // ready. A vector with a negative x is turned by 180 degrees first.
  logic signed [FLT_W:0] ey;
  logic signed [FLT_W:0] ex;
  logic signed [FLT_W:0] ey_n;
  logic signed [FLT_W:0] ex_n;
  cordic_bus_t           chain_bus [0:CORDIC_STEPS];

  always_comb begin
    if (state_r == S_ROOT) begin
      ey = (FLT_W+1)'(fy_r);
      ex = $signed({1'b0, sqrt_root});
    end else begin
      ey = -(FLT_W+1)'(fx_r);
      ex = (FLT_W+1)'(fz_r);
    end
    chain_bus[0].vld = (state_r == S_MUL) || (state_r == S_ROOT && sqrt_done);
    chain_bus[0].roll = (state_r == S_ROOT);
    if (ex < 0) begin
      ex_n = -ex;
      ey_n = -ey;
      chain_bus[0].z = (ey >= 0) ? DEG180_Q20 : -DEG180_Q20;
    end else begin
      ex_n = ex;
      ey_n = ey;
      chain_bus[0].z = '0;
    end
    chain_bus[0].x = $signed({(CX_W-16)'(ex_n), 16'b0});
    chain_bus[0].y = $signed({(CX_W-16)'(ey_n), 16'b0});
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_chain
    tdc_cordic_cell #(
      .STAGE (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .bus_in  (chain_bus[k]),
      .bus_out (chain_bus[k+1])
    );
  end

  logic signed [Z_W-1:0] zp_r;
  logic signed [Z_W-1:0] zr_r;
  logic                  roll_out;

  assign roll_out = chain_bus[CORDIC_STEPS].vld && chain_bus[CORDIC_STEPS].roll;

  always_ff @(posedge clk) begin
    if (chain_bus[CORDIC_STEPS].vld && !chain_bus[CORDIC_STEPS].roll) begin
      zp_r <= chain_bus[CORDIC_STEPS].z;
    end
    if (roll_out) begin
      zr_r <= chain_bus[CORDIC_STEPS].z;
    end
  end

  // Round half up to the angle format, then clamp to the angle's range.
  function automatic logic signed [ANG_W-1:0] round_clamp(
    input logic signed [Z_W-1:0] z,
    input int                    lim
  );
    logic signed [30:0]   rnd;
    logic signed [RW-1:0] a;
    logic signed [RW-1:0] l;
    rnd = 31'(z) + (31'sd1 <<< (SH - 1));
    a = rnd[30:SH];
    l = RW'(lim);
    if (a > l) begin
      a = l;
    end else if (a < -l) begin
      a = -l;
    end
    return a[ANG_W-1:0];
  endfunction

  logic signed [ANG_W-1:0] pitch_r;
  logic signed [ANG_W-1:0] roll_r;

  always_ff @(posedge clk) begin
    if (state_r == S_ANG) begin
      pitch_r <= round_clamp(zp_r, PITCH_LIM);
      roll_r <= round_clamp(zr_r, ROLL_LIM);
    end
  end

  // Deadzone mapping. The quotient 100*(|a|-t)/(90-t) is taken on the
  // magnitude; the low fraction bits cancel out of numerator and divisor.
  logic [DZ_W-1:0]     pt;
  logic [DZ_W-1:0]     rt;
  logic [ANG_W-1:0]    pmag;
  logic [ANG_W-1:0]    rmag;
  logic [ANG_W-1:0]    pth;
  logic [ANG_W-1:0]    rth;
  logic                pout;
  logic                rout;
  logic [PROD_W-1:0]   pprod;
  logic [PROD_W-1:0]   rprod;
  logic [QN_W-1:0]     pquot;
  logic [QN_W-1:0]     rquot;
  logic                pdiv_done;
  logic                rdiv_done;

  assign pt = (pdz_r > DZ_MAX) ? DZ_MAX : pdz_r;
  assign rt = (rdz_r > DZ_MAX) ? DZ_MAX : rdz_r;
  assign pth = ANG_W'(pt) << ANGLE_FRAC_BITS;
  assign rth = ANG_W'(rt) << ANGLE_FRAC_BITS;
  assign pmag = pitch_r[ANG_W-1] ? ANG_W'(-pitch_r) : ANG_W'(pitch_r);
  assign rmag = roll_r[ANG_W-1] ? ANG_W'(-roll_r) : ANG_W'(roll_r);
  assign pout = (pmag > pth);
  assign rout = (rmag > rth);
  assign pprod = pout ? PROD_W'(pmag - pth) * PROD_W'(DRIVE_MAX) : '0;
  assign rprod = rout ? PROD_W'(rmag - rth) * PROD_W'(DRIVE_MAX) : '0;

  tdc_div u_div_speed (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DIVGO),
    .num   (pprod[ANGLE_FRAC_BITS +: QN_W]),
    .den   (DEG90 - pt),
    .done  (pdiv_done),
    .quot  (pquot)
  );

  tdc_div u_div_steer (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DIVGO),
    .num   (rprod[ANGLE_FRAC_BITS +: QN_W]),
    .den   (DEG90 - rt),
    .done  (rdiv_done),
    .quot  (rquot)
  );

  function automatic logic signed [7:0] drive(
    input logic            outside,
    input logic            neg,
    input logic [QN_W-1:0] q
  );
    logic [6:0] qs;
    qs = (q > QN_W'(DRIVE_MAX)) ? DRIVE_MAX : q[6:0];
    if (!outside) begin
      return '0;
    end
    return neg ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
  endfunction

  // Output register; a finished result waits here while the next sample is
  // taken in.
  logic                   out_valid_r;
  logic                   load;
  logic signed [7:0]      speed_r;
  logic signed [7:0]      steer_r;
  logic signed [16:0]     pang_r;
  logic signed [15:0]     rang_r;
  logic signed [31:0]     pitch_ext;
  logic signed [31:0]     roll_ext;

  assign load = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign pitch_ext = 32'(pitch_r);
  assign roll_ext = 32'(roll_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      speed_r <= drive(pout, pitch_r[ANG_W-1], pquot);
      steer_r <= drive(rout, roll_r[ANG_W-1], rquot);
      pang_r <= pitch_ext[16:0];
      rang_r <= roll_ext[15:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_speed = speed_r;
  assign out_steering = steer_r;
  assign out_pitch_angle = pang_r;
  assign out_roll_angle = rang_r;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_MUL;
      S_MUL: state_nxt = S_SUM;
      S_SUM: state_nxt = S_ROOT;
      S_ROOT: if (sqrt_done) state_nxt = S_CORD;
      S_CORD: if (roll_out) state_nxt = S_ANG;
      S_ANG: state_nxt = S_DIVGO;
      S_DIVGO: state_nxt = S_DIVW;
      S_DIVW: if (pdiv_done) state_nxt = S_OUT;
      S_OUT: if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The roll vector leaves the chain only while the sequencer waits for it.
  a_roll_exit: assert property (@(posedge clk) disable iff (!rst_n)
    roll_out |-> state_r == S_CORD)
    else $error("roll left the CORDIC chain outside its wait state");

  // The chain is empty whenever a new sample can be taken.
  a_chain_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !chain_bus[CORDIC_STEPS].vld)
    else $error("CORDIC chain busy while accepting a sample");

  // Both dividers run in lockstep.
  a_div_sync: assert property (@(posedge clk) disable iff (!rst_n)
    pdiv_done == rdiv_done)
    else $error("deadzone dividers out of step");

  // Drive commands stay within plus or minus 100.
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (speed_r <= 8'sd100 && speed_r >= -8'sd100 &&
                     steer_r <= 8'sd100 && steer_r >= -8'sd100))
    else $error("drive command out of range");

endmodule

`default_nettype wire

>>> test/tdc_checker.sv
// ----------------------------------------------------------------------------
// tdc_checker
// Watches the sample and command channels of the tilt to drive command block,
// predicts every command from its own copy of the filter state and settings,
// and compares each command as a whole.
// ----------------------------------------------------------------------------
module tdc_checker
  import tdc_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_addr,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic signed [SMP_W-1:0] in_accel_x,
  input  logic signed [SMP_W-1:0] in_accel_y,
  input  logic signed [SMP_W-1:0] in_accel_z,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [7:0]       out_speed,
  input  logic signed [7:0]       out_steering,
  input  logic signed [16:0]      out_pitch_angle,
  input  logic signed [15:0]      out_roll_angle,
  output int                      fail_count,
  output int                      pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [7:0]  speed;
    logic signed [7:0]  steering;
    logic signed [16:0] pitch;
    logic signed [15:0] roll;
  } drive_cmd_t;

  drive_cmd_t cmd_queue[$];
  longint     smooth_x, smooth_y, smooth_z;
  int unsigned weight, pitch_dz, roll_dz;

  assign pending_count = cmd_queue.size();

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint smooth(longint old, longint s, longint w);
    longint p;
    p = w * s * 256 + (256 - w) * old;
    return floor_shift(p, 8);
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint ang, dx, dy;
    int sh;
    sh = 20 - ANGLE_FRAC_BITS;
    if (x == 0 && y == 0) return 0;
    ang = 0;
    // Left half plane: turn by 180 degrees first.
    if (x < 0) begin
      ang = (y >= 0) ? 64'sd188743680 : -64'sd188743680;
      x = -x;
      y = -y;
    end
    x *= 65536;
    y *= 65536;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; ang += longint'(atan_q20(i));
      end else if (y < 0) begin
        x -= dx; y += dy; ang -= longint'(atan_q20(i));
      end
    end
    return (ang + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint limit(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint drive_level(longint a, longint t);
    longint th, den, v;
    if (t > 89) t = 89;
    th = t <<< ANGLE_FRAC_BITS;
    den = (90 - t) <<< ANGLE_FRAC_BITS;
    if (a > th) v = (100 * (a - th)) / den;
    else if (a < -th) v = -((100 * (-a - th)) / den);
    else v = 0;
    return limit(v, 100);
  endfunction

  function automatic drive_cmd_t predict_cmd(longint sx, longint sy, longint sz);
    drive_cmd_t c;
    longint p, r, m;
    p = limit(vector_angle(-sx, sz), 64'sd180 <<< ANGLE_FRAC_BITS);
    m = int_sqrt(longint'(sx * sx + sz * sz));
    r = limit(vector_angle(sy, m), 64'sd90 <<< ANGLE_FRAC_BITS);
    c.speed = 8'(drive_level(p, pitch_dz));
    c.steering = 8'(drive_level(r, roll_dz));
    c.pitch = 17'(p);
    c.roll = 16'(r);
    return c;
  endfunction

  always @(posedge clk) begin
    longint w;
    drive_cmd_t want, got;
    if (!rst_n) begin
      weight <= 128; pitch_dz <= 10; roll_dz <= 10;
      smooth_x = 0; smooth_y = 0; smooth_z = 0;
      cmd_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_WEIGHT:   weight <= cfg_wdata;
          CFG_PITCH_DZ: pitch_dz <= cfg_wdata[DZ_W-1:0];
          CFG_ROLL_DZ:  roll_dz <= cfg_wdata[DZ_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        w = (weight > 256) ? 256 : weight;
        smooth_x = smooth(smooth_x, in_accel_x, w);
        smooth_y = smooth(smooth_y, in_accel_y, w);
        smooth_z = smooth(smooth_z, in_accel_z, w);
        cmd_queue.push_back(predict_cmd(smooth_x, smooth_y, smooth_z));
      end
      if (out_valid && out_ready) begin
        got = '{out_speed, out_steering, out_pitch_angle, out_roll_angle};
        if (cmd_queue.size() == 0) begin
          $display("%0t: unexpected command, got %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = cmd_queue.pop_front();
          if (got !== want) begin
            $display("%0t: command mismatch, expected %p, actual %p", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives samples and register writes into the tilt to drive command block
// under several idling patterns; the checker beside it predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import tdc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = CFG_WEIGHT;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SMP_W-1:0] in_accel_x = '0, in_accel_y = '0, in_accel_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [7:0] out_speed, out_steering;
  logic signed [16:0] out_pitch_angle;
  logic signed [15:0] out_roll_angle;
  int fail_count, pending_count;
  int send_idle_pct = 0, stall_pct = 0;
  longint cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tilt_to_drive_command dut (.*);
  tdc_checker chk (.*);

  // Transactions can meet long stalls on both sides; this limit is many times
  // the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The receiver stalls at random with the current stall percentage.
  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Presents one sample, holding it until the block takes it.
  task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] az);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_accel_x <= ax;
    in_accel_y <= ay;
    in_accel_z <= az;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until all commands are back, then lets the block settle so a
  // register write cannot land while it is working.
  task automatic drain();
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(32)) - 16'd16;
      default: return 16'($urandom);
    endcase
  endfunction

  // A tilt sample: gravity of about 16384 counts spread over the axes with
  // noise, so the filters settle at angles spread over the whole circle.
  task automatic send_tilt();
    int g;
    g = $urandom_range(16000, 17000);
    case ($urandom_range(3))
      0: send_sample(pick_axis(), pick_axis(), pick_axis());
      default: send_sample(16'($signed(g) * ($signed($urandom_range(200)) - 100) / 100),
                           16'($signed(g) * ($signed($urandom_range(200)) - 100) / 100),
                           16'($signed(g) * ($signed($urandom_range(200)) - 100) / 100));
    endcase
  endtask

  initial begin
    int settings[5][3] = '{'{128, 10, 10}, '{256, 0, 0}, '{0, 89, 89},
                           '{511, 127, 127}, '{1, 45, 3}};
    int idle[5][2] = '{'{0, 0}, '{86, 0}, '{0, 86}, '{10, 10}, '{0, 0}};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first at reset defaults, then at full weight: extremes, zero vector, each quadrant.
    send_sample(16'h0000, 16'h0000, 16'h0000);
    drain();
    write_reg(CFG_WEIGHT, 256);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h8000, 16'h0000, 16'h0000);
    send_sample(16'h7fff, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0000, 16'h8000);
    send_sample(16'h0000, 16'h8000, 16'h0000);
    send_sample(16'h0001, 16'hffff, 16'h8000);
    send_sample(16'hffff, 16'h0001, 16'h8000);
    send_sample(16'h0000, 16'h7fff, 16'h7fff);
    send_sample(16'h5555, 16'haaaa, 16'h5555);
    send_sample(16'haaaa, 16'h5555, 16'haaaa);
    send_sample(16'h0000, 16'h0000, 16'h0000);
    drain();

    // Random part: each phase picks a setting and an idling pattern.
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_WEIGHT, settings[ph % 5][0]);
      write_reg(CFG_PITCH_DZ, settings[ph % 5][1]);
      write_reg(CFG_ROLL_DZ, settings[ph % 5][2]);
      send_idle_pct = idle[ph % 5][0];
      stall_pct = idle[ph % 5][1];
      for (int i = 0; i < 153; i++) send_tilt();
      drain();
    end

    drain();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
